// ----- sv/lpsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsc_pkg
// Shared types and constants of the length-prefixed string carver.
// ----------------------------------------------------------------------------
package lpsc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } item_t;

    typedef struct packed {
        logic        hit_valid;
        logic [31:0] hit_offset;
        logic [7:0]  hit_length;
        logic        scan_done;
    } result_t;

    // One window entry: the byte and the running counts up to and including it.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] bad_count;
        logic [7:0] letter_count;
    } entry_t;

    localparam logic [7:0]  PRINT_LOW      = 8'd32;
    localparam logic [7:0]  DEL_CHAR       = 8'd127;
    localparam logic [7:0]  TERM_ZERO      = 8'h00;
    localparam logic [7:0]  TERM_ONES      = 8'hFF;
    localparam logic [31:0] COUNT_TOP      = 32'hFFFF_FFFF;
    localparam logic [7:0]  MAX_LEN_RESET  = 8'd128;
    localparam logic [4:0]  MAX_HITS       = 5'd27;
    localparam logic        REG_MAX_LEN    = 1'b0;
    localparam logic        REG_START_LIM  = 1'b1;

endpackage

// ----- sv/lpsc_window_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsc_window_mem
// Window memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lpsc_window_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  lpsc_pkg::entry_t     wdata,
    input  logic [AW-1:0]        raddr,
    output lpsc_pkg::entry_t     rdata
);

    lpsc_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/length_prefixed_string_carver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_string_carver_unit
// Scans a byte stream for length-prefixed printable strings and reports hits.
//
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_stall      lpsc_pkg::item_t
// result    out        result_valid / result_stall  lpsc_pkg::result_t
// apb       in/out     psel / penable / pready      paddr, pwdata, prdata
//
// A byte is stored in S_IDLE; every scan offset then passes S_CHECK and S_P1
// to S_P4 when its prefix is out of range or incomplete, and S_END when the
// string counts are checked, all through the single read port of the window
// memory. A terminator check uses S_TERM. Reset clears all control state at
// once. A stalled result holds the scan until the output register frees.
// ----------------------------------------------------------------------------
module length_prefixed_string_carver_unit #(
    parameter int WINDOW_DEPTH  = 256,
    parameter int MAX_LEN_BOUND = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  lpsc_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output lpsc_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW      = $clog2(WINDOW_DEPTH);
    localparam int LEN_LIM = (MAX_LEN_BOUND < WINDOW_DEPTH - 6) ?
                             MAX_LEN_BOUND : WINDOW_DEPTH - 6;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(WINDOW_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_P1    = 4'd2;
    localparam logic [3:0] S_P2    = 4'd3;
    localparam logic [3:0] S_P3    = 4'd4;
    localparam logic [3:0] S_P4    = 4'd5;
    localparam logic [3:0] S_END   = 4'd6;
    localparam logic [3:0] S_TERM  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + b;
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    logic [3:0]        state_reg, state_next;
    logic [7:0]        max_len_reg;
    logic [31:0]       start_limit_reg;
    logic [31:0]       rcv_reg, rcv_next;
    logic [31:0]       scan_reg, scan_next;
    logic [AW-1:0]     wptr_reg, wptr_next;
    logic [AW-1:0]     sptr_reg, sptr_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic              pend_reg, pend_next;
    logic              final_reg, final_next;
    logic [7:0]        bad_run_reg, bad_run_next;
    logic [7:0]        let_run_reg, let_run_next;
    logic [4:0]        hits_reg, hits_next;
    logic [7:0]        b0_reg, b0_next, b1_reg, b1_next, b2_reg, b2_next;
    logic [7:0]        len_reg, len_next;
    logic [7:0]        base_bad_reg, base_bad_next, base_let_reg, base_let_next;
    logic              out_valid_reg, out_valid_next;
    lpsc_pkg::result_t out_reg, out_next;

    logic              mem_we;
    lpsc_pkg::entry_t  mem_wdata, mem_rdata;
    logic              in_bad, in_letter, accept, out_free;
    logic [7:0]        maxl;
    logic [32:0]       end_pos;
    logic [7:0]        bad_diff, let_diff;

    lpsc_window_mem #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wptr_reg),
        .wdata (mem_wdata),
        .raddr (addr_next),
        .rdata (mem_rdata)
    );

    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == lpsc_pkg::REG_START_LIM) ? start_limit_reg :
                          {24'd0, max_len_reg};
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign accept       = item_valid && !item_stall;
    assign out_free     = !out_valid_reg || !result_stall;

    assign in_bad    = (item.data_byte < lpsc_pkg::PRINT_LOW) ||
                       (item.data_byte == lpsc_pkg::DEL_CHAR);
    assign in_letter = (item.data_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    assign maxl      = (32'(max_len_reg) > 32'(LEN_LIM)) ? 8'(LEN_LIM) : max_len_reg;
    assign end_pos   = {1'b0, scan_reg} + 33'd4 + 33'(len_reg);
    assign bad_diff  = mem_rdata.bad_count - base_bad_reg;
    assign let_diff  = mem_rdata.letter_count - base_let_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg     <= lpsc_pkg::MAX_LEN_RESET;
            start_limit_reg <= 32'd0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == lpsc_pkg::REG_MAX_LEN)
            begin
                max_len_reg <= pwdata[7:0];
            end
            else
            begin
                start_limit_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rcv_next       = rcv_reg;
        scan_next      = scan_reg;
        wptr_next      = wptr_reg;
        sptr_next      = sptr_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        final_next     = final_reg;
        bad_run_next   = bad_run_reg;
        let_run_next   = let_run_reg;
        hits_next      = hits_reg;
        b0_next        = b0_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        len_next       = len_reg;
        base_bad_next  = base_bad_reg;
        base_let_next  = base_let_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_wdata.data         = item.data_byte;
        mem_wdata.bad_count    = bad_run_reg + 8'(in_bad);
        mem_wdata.letter_count = let_run_reg + 8'(in_letter);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    final_next = item.is_final;
                    hits_next  = 5'd0;
                    state_next = S_CHECK;
                    if (rcv_reg != lpsc_pkg::COUNT_TOP)
                    begin
                        mem_we       = 1'b1;
                        bad_run_next = mem_wdata.bad_count;
                        let_run_next = mem_wdata.letter_count;
                        rcv_next     = rcv_reg + 32'd1;
                        wptr_next    = wrap_add(wptr_reg, (AW + 1)'(1));
                    end
                end
            end
            S_CHECK:
            begin
                if (pend_reg && (scan_reg < rcv_reg))
                begin
                    addr_next  = sptr_reg;
                    state_next = S_TERM;
                end
                else if (pend_reg && !final_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else if (((start_limit_reg != 32'd0) &&
                          ({1'b0, scan_reg} + 33'd4 > {1'b0, start_limit_reg})) ||
                         ({1'b0, scan_reg} + 33'd4 > {1'b0, rcv_reg}))
                begin
                    state_next = final_reg ? S_FIN : S_IDLE;
                end
                else
                begin
                    addr_next  = sptr_reg;
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                b0_next    = mem_rdata.data;
                addr_next  = wrap_add(sptr_reg, (AW + 1)'(1));
                state_next = S_P2;
            end
            S_P2:
            begin
                b1_next    = mem_rdata.data;
                addr_next  = wrap_add(sptr_reg, (AW + 1)'(2));
                state_next = S_P3;
            end
            S_P3:
            begin
                b2_next    = mem_rdata.data;
                addr_next  = wrap_add(sptr_reg, (AW + 1)'(3));
                state_next = S_P4;
            end
            S_P4:
            begin
                len_next      = b0_reg;
                base_bad_next = mem_rdata.bad_count;
                base_let_next = mem_rdata.letter_count;
                if ((mem_rdata.data != 8'd0) || (b2_reg != 8'd0) || (b1_reg != 8'd0) ||
                    (b0_reg == 8'd0) || (b0_reg > maxl))
                begin
                    scan_next  = scan_reg + 32'd1;
                    sptr_next  = wrap_add(sptr_reg, (AW + 1)'(1));
                    state_next = S_CHECK;
                end
                else if ({1'b0, scan_reg} + 33'd4 + 33'(b0_reg) > {1'b0, rcv_reg})
                begin
                    if (final_reg)
                    begin
                        scan_next  = scan_reg + 32'd1;
                        sptr_next  = wrap_add(sptr_reg, (AW + 1)'(1));
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    addr_next  = wrap_add(sptr_reg, (AW + 1)'(3) + (AW + 1)'(b0_reg));
                    state_next = S_END;
                end
            end
            S_END:
            begin
                if ((bad_diff == 8'd0) && (let_diff != 8'd0))
                begin
                    if (hits_reg < lpsc_pkg::MAX_HITS)
                    begin
                        if (out_free)
                        begin
                            out_valid_next       = 1'b1;
                            out_next.hit_valid   = 1'b1;
                            out_next.hit_offset  = scan_reg;
                            out_next.hit_length  = len_reg;
                            out_next.scan_done   = 1'b0;
                            hits_next            = hits_reg + 5'd1;
                            scan_next            = end_pos[31:0];
                            sptr_next  = wrap_add(sptr_reg, (AW + 1)'(4) + (AW + 1)'(len_reg));
                            pend_next            = 1'b1;
                            state_next           = S_CHECK;
                        end
                    end
                    else
                    begin
                        scan_next  = end_pos[31:0];
                        sptr_next  = wrap_add(sptr_reg, (AW + 1)'(4) + (AW + 1)'(len_reg));
                        pend_next  = 1'b1;
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    scan_next  = scan_reg + 32'd1;
                    sptr_next  = wrap_add(sptr_reg, (AW + 1)'(1));
                    state_next = S_CHECK;
                end
            end
            S_TERM:
            begin
                if ((mem_rdata.data == lpsc_pkg::TERM_ZERO) ||
                    (mem_rdata.data == lpsc_pkg::TERM_ONES))
                begin
                    scan_next = scan_reg + 32'd1;
                    sptr_next = wrap_add(sptr_reg, (AW + 1)'(1));
                end
                pend_next  = 1'b0;
                state_next = S_CHECK;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.hit_valid  = 1'b0;
                    out_next.hit_offset = 32'd0;
                    out_next.hit_length = 8'd0;
                    out_next.scan_done  = 1'b1;
                    rcv_next            = 32'd0;
                    scan_next           = 32'd0;
                    wptr_next           = '0;
                    sptr_next           = '0;
                    pend_next           = 1'b0;
                    bad_run_next        = 8'd0;
                    let_run_next        = 8'd0;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rcv_reg       <= 32'd0;
            scan_reg      <= 32'd0;
            wptr_reg      <= '0;
            sptr_reg      <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            final_reg     <= 1'b0;
            bad_run_reg   <= 8'd0;
            let_run_reg   <= 8'd0;
            hits_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rcv_reg       <= rcv_next;
            scan_reg      <= scan_next;
            wptr_reg      <= wptr_next;
            sptr_reg      <= sptr_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            final_reg     <= final_next;
            bad_run_reg   <= bad_run_next;
            let_run_reg   <= let_run_next;
            hits_reg      <= hits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg       <= b0_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        len_reg      <= len_next;
        base_bad_reg <= base_bad_next;
        base_let_reg <= base_let_next;
        out_reg      <= out_next;
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed string carver.
//
// A behavioral scan model predicts the hits and end markers of every byte
// transfer. A scoreboard compares each result transfer with the oldest
// prediction. Bytes are offered in random bursts, results are stalled on a
// random pattern, and both registers are swept between streams.
// ----------------------------------------------------------------------------
class carver_scoreboard;
    lpsc_pkg::result_t pending_hits[$];
    logic [7:0]  window_bytes[256];
    logic [31:0] received;
    logic [31:0] scan_pos;
    logic        term_pending;
    logic [7:0]  max_len;
    logic [31:0] limit;
    int          mismatches;
    int          hits_seen;
    int          markers_seen;

    function new();
        max_len = 8'd128;
        limit = 32'd0;
        mismatches = 0;
        hits_seen = 0;
        markers_seen = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        received = 32'd0;
        scan_pos = 32'd0;
        term_pending = 1'b0;
    endfunction

    function logic [7:0] byte_at(logic [63:0] pos);
        return window_bytes[pos[7:0]];
    endfunction

    function void note_byte(lpsc_pkg::item_t it);
        logic [63:0] i;
        logic [63:0] rcv;
        logic [63:0] len;
        logic [63:0] maxl;
        logic [7:0]  c;
        logic        ok;
        logic        letter;
        int          n;
        lpsc_pkg::result_t r;
        n = 0;
        maxl = (max_len > 8'd128) ? 64'd128 : 64'(max_len);
        if (received != 32'hFFFF_FFFF)
        begin
            window_bytes[received[7:0]] = it.data_byte;
            received++;
        end
        forever
        begin
            i = 64'(scan_pos);
            rcv = 64'(received);
            if (term_pending)
            begin
                if (i < rcv)
                begin
                    c = byte_at(i);
                    if (c == lpsc_pkg::TERM_ZERO || c == lpsc_pkg::TERM_ONES)
                        scan_pos++;
                    term_pending = 1'b0;
                    continue;
                end
                if (!it.is_final)
                    break;
                term_pending = 1'b0;
            end
            if (limit != 0 && i + 4 > 64'(limit))
                break;
            if (i + 4 > rcv)
                break;
            len = 64'({byte_at(i + 3), byte_at(i + 2), byte_at(i + 1), byte_at(i)});
            if (len == 0 || len > maxl)
            begin
                scan_pos++;
                continue;
            end
            if (i + 4 + len > rcv)
            begin
                if (!it.is_final)
                    break;
                scan_pos++;
                continue;
            end
            ok = 1'b1;
            letter = 1'b0;
            for (int k = 0; k < len; k++)
            begin
                c = byte_at(i + 4 + 64'(k));
                if (c < lpsc_pkg::PRINT_LOW || c == lpsc_pkg::DEL_CHAR)
                begin
                    ok = 1'b0;
                    break;
                end
                if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
                    letter = 1'b1;
            end
            if (ok && letter)
            begin
                if (n < 27)
                begin
                    r = '{1'b1, i[31:0], len[7:0], 1'b0};
                    pending_hits = {pending_hits, r};
                    n++;
                end
                scan_pos = 32'(i + 4 + len);
                term_pending = 1'b1;
                continue;
            end
            scan_pos++;
        end
        if (it.is_final)
        begin
            r = '{1'b0, 32'd0, 8'd0, 1'b1};
            pending_hits = {pending_hits, r};
            clear_stream();
        end
    endfunction

    function void check_result(lpsc_pkg::result_t got);
        lpsc_pkg::result_t want;
        if (pending_hits.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result %p", got));
            return;
        end
        want = pending_hits.pop_front();
        if (got.hit_valid !== want.hit_valid || got.hit_offset !== want.hit_offset ||
            got.hit_length !== want.hit_length || got.scan_done !== want.scan_done)
            report_mismatch($sformatf("got %p expected %p", got, want));
        if (want.hit_valid)
            hits_seen++;
        else
            markers_seen++;
    endfunction

    function void report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endfunction
endclass

module testbench;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    lpsc_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    lpsc_pkg::result_t result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    carver_scoreboard scoreboard;
    int  idle_cycles;
    int  bytes_sent;
    bit  hold_off;
    bit  stall_busy;

    length_prefixed_string_carver_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        scoreboard = new();
        rst_n = 0;
        item_valid = 0;
        item = '0;
        result_stall = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        hold_off = 0;
        stall_busy = 0;
        bytes_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
    end

    // Result receiver: random stall pattern, with an optional long hold-off.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            scoreboard.check_result(result);
        if (hold_off)
            result_stall <= 1;
        else if (stall_busy)
            result_stall <= ($urandom_range(0, 2) == 0);
        else
            result_stall <= 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("length_prefixed_string_carver_unit verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic set_config(input logic [7:0] max_len, input logic [31:0] limit);
        write_reg(3'd4 * 3'(lpsc_pkg::REG_MAX_LEN), {24'd0, max_len});
        write_reg(3'd4 * 3'(lpsc_pkg::REG_START_LIM), limit);
        scoreboard.max_len = max_len;
        scoreboard.limit = limit;
    endtask

    // Offers one byte; while item_valid is still high a random gap may precede it.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        lpsc_pkg::item_t it;
        it.data_byte = b;
        it.is_final = fin;
        if (item_valid && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid <= 1;
        item <= it;
        do @(posedge clk); while (item_stall);
        scoreboard.note_byte(it);
        bytes_sent++;
    endtask

    task automatic end_offer();
        item_valid <= 0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (scoreboard.pending_hits.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
    endtask

    task automatic send_string(input logic [31:0] len, input bit good);
        for (int k = 0; k < 4; k++)
            send_byte(len[8*k +: 8], 0);
        for (int k = 0; k < len; k++)
        begin
            if (!good && $urandom_range(0, 7) == 0)
                send_byte($urandom_range(0, 1) ? 8'd127 : 8'($urandom_range(0, 31)), 0);
            else if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(128, 255)), 0);
            else if ($urandom_range(0, 3) == 0)
                send_byte(8'($urandom_range(32, 64)), 0);
            else
                send_byte($urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                               : 8'($urandom_range(97, 122)), 0);
        end
        case ($urandom_range(0, 3))
            0: send_byte(lpsc_pkg::TERM_ZERO, 0);
            1: send_byte(lpsc_pkg::TERM_ONES, 0);
            default: ;
        endcase
    endtask

    task automatic random_stream(input logic [7:0] max_len);
        int parts;
        parts = $urandom_range(1, 4);
        for (int p = 0; p < parts; p++)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 0);
            else
                send_string($urandom_range(1, (max_len == 0) ? 6 : max_len + 1),
                            $urandom_range(0, 4) != 0);
        end
        send_byte(8'($urandom), 1);
    endtask

    initial
    begin
        logic [7:0] lens[6];
        wait (rst_n);
        repeat (2) @(posedge clk);
        lens = '{8'd1, 8'd0, 8'd128, 8'd255, 8'd12, 8'd3};

        // Directed streams.
        set_config(8'd128, 32'd0);
        send_byte(8'd1, 0); send_byte(8'd0, 0); send_byte(8'd0, 0); send_byte(8'd0, 0);
        send_byte("a", 0); send_byte(lpsc_pkg::TERM_ZERO, 0);
        send_byte(8'd1, 0); send_byte(8'd0, 0); send_byte(8'd0, 0); send_byte(8'd0, 0);
        send_byte("Z", 1);
        send_byte(8'd2, 0); send_byte(8'd0, 0); send_byte(8'd0, 0); send_byte(8'd0, 0);
        send_byte("1", 0); send_byte(8'd255, 0); send_byte(8'd5, 1);
        send_byte(8'd5, 0); send_byte(8'd0, 0); send_byte(8'd0, 0); send_byte(8'd0, 0);
        send_byte("x", 1);
        send_byte(8'hFF, 1);
        end_offer();
        drain();

        set_config(8'd0, 32'd0);
        send_string(3, 1);
        send_byte(8'd0, 1);
        end_offer();
        drain();

        set_config(8'd255, 32'd6);
        send_string(20, 1);
        send_string(2, 1);
        send_byte(8'd0, 1);
        end_offer();
        drain();

        set_config(8'd200, 32'hFFFF_FFFF);
        send_string(129, 1);
        send_byte(8'd0, 1);
        end_offer();
        drain();

        // Long receiver hold-off so the block backs up.
        stall_busy = 1;
        set_config(8'd8, 32'd0);
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            repeat (12) send_string(1, 1);
        join
        send_byte(8'd0, 1);
        end_offer();
        drain();

        // Random streams under swept settings.
        while (bytes_sent < 370)
        begin
            logic [7:0] ml;
            ml = lens[$urandom_range(0, 5)];
            if ($urandom_range(0, 1))
                ml = 8'($urandom_range(1, 40));
            set_config(ml, $urandom_range(0, 2) == 0 ? $urandom_range(4, 60) : 32'd0);
            stall_busy = $urandom_range(0, 2) != 0;
            repeat ($urandom_range(1, 3)) random_stream(ml > 40 ? 8'd40 : ml);
            end_offer();
            drain();
        end

        $display("Sent %0d bytes; checked %0d hits and %0d end markers.",
                 bytes_sent, scoreboard.hits_seen, scoreboard.markers_seen);
        if (scoreboard.mismatches == 0 && scoreboard.pending_hits.size() == 0)
            $display("length_prefixed_string_carver_unit verification clean");
        else
            $display("length_prefixed_string_carver_unit verification failed");
        $finish;
    end
endmodule
